// File: hdl/rtba_pkg.sv
// rtba_pkg: shared types, codes and constants of the region table block allocator.
// Depends on nothing; imported by every module in hdl/.
`timescale 1ns / 1ps

package rtba_pkg;

    // Default table depth
    localparam int NUM_REGIONS_DEF = 8;

    // Address arithmetic constants
    localparam logic [15:0] CHIP_TYPE  = 16'h0002;
    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_0000;
    localparam logic [31:0] BLOCK_SIZE = 32'h0001_0000;

    // Operation codes (code 3 is unused and does nothing)
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_LARGEST = 2'd2;

    // One request
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  entry_index;
        logic [15:0] entry_type;
        logic [31:0] entry_start;
        logic [31:0] entry_end;
    } req_t;

    // One result
    typedef struct packed {
        logic [31:0] block_address;
        logic [31:0] block_size;
        logic        granted;
        logic        all_ok;
    } res_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC_SCAN,
        ST_FREE_SCAN,
        ST_ALLOC_WRITE,
        ST_BIG_SCAN,
        ST_BIG_WRITE
    } state_t;

    // Which result the datapath builds on finish
    typedef enum logic [1:0] {
        RES_FAIL,
        RES_LOAD,
        RES_ALLOC,
        RES_BIG
    } res_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      capture;
        logic      ptr_clr;
        logic      ptr_inc;
        logic      hit_save;
        logic      best_en;
        logic      wr_load;
        logic      wr_leftover;
        logic      wr_hit_end;
        logic      wr_best_end;
        logic      clr_ok;
        logic      finish;
        res_kind_t res_kind;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       load_ok;
        logic       last;
        logic       alloc_hit;
        logic       need_split;
        logic       slot_empty;
        logic       best_found;
    } status_t;

endpackage

// File: hdl/rtba_dp.sv
// rtba_dp: datapath of the region table allocator: region table, scan pointer,
// hit and best trackers, ok flag and result register. Depends on rtba_pkg.
`timescale 1ns / 1ps

module rtba_dp
    import rtba_pkg::*;
#(
    parameter int NUM_REGIONS = NUM_REGIONS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    request,
    input  cmd_t    cmd,
    output status_t status,
    output res_t    result,
    output logic    done
);

    localparam int IDX_W = $clog2(NUM_REGIONS);

    // Region table
    logic [15:0] type_reg  [NUM_REGIONS];
    logic [31:0] start_reg [NUM_REGIONS];
    logic [31:0] end_reg   [NUM_REGIONS];

    req_t             req_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [31:0]      hit_top_reg;
    logic [31:0]      hit_addr_reg;
    logic [31:0]      hit_end_reg;
    logic [15:0]      hit_type_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_start_reg;
    logic [31:0]      best_size_reg;
    logic             best_found_reg;
    logic             ok_reg;
    res_t             result_reg;
    res_t             result_next;
    logic             done_reg;

    logic [15:0]      rd_type;
    logic [31:0]      rd_start;
    logic [31:0]      rd_end;
    logic [31:0]      rd_top;
    logic [31:0]      rd_addr;
    logic [31:0]      rd_size;
    logic             rd_bigger;

    logic             we_type;
    logic             we_start;
    logic             we_end;
    logic [IDX_W-1:0] waddr;
    logic [15:0]      wtype;
    logic [31:0]      wstart;
    logic [31:0]      wend;

    // Read the entry under the scan pointer
    assign rd_type   = type_reg[ptr_reg];
    assign rd_start  = start_reg[ptr_reg];
    assign rd_end    = end_reg[ptr_reg];
    assign rd_top    = rd_end & ALIGN_MASK;
    assign rd_addr   = rd_top - BLOCK_SIZE;
    assign rd_size   = rd_end - rd_start;
    assign rd_bigger = (rd_end != 32'd0) && (rd_size > best_size_reg);

    // Status back to the controller
    always_comb
    begin
        status.op         = req_reg.op;
        status.load_ok    = (32'(req_reg.entry_index) < 32'(NUM_REGIONS));
        status.last       = (ptr_reg == IDX_W'(NUM_REGIONS - 1));
        status.alloc_hit  = (rd_end != 32'd0) && (rd_type == CHIP_TYPE)
                            && (rd_top >= BLOCK_SIZE) && (rd_addr >= rd_start);
        status.need_split = (rd_top < rd_end);
        status.slot_empty = (rd_end == 32'd0);
        status.best_found = best_found_reg;
    end

    // Single table write port
    always_comb
    begin
        we_type  = 1'b0;
        we_start = 1'b0;
        we_end   = 1'b0;
        waddr    = ptr_reg;
        wtype    = req_reg.entry_type;
        wstart   = req_reg.entry_start;
        wend     = req_reg.entry_end;
        if (cmd.wr_load)
        begin
            we_type  = 1'b1;
            we_start = 1'b1;
            we_end   = 1'b1;
            waddr    = IDX_W'(req_reg.entry_index);
        end
        else if (cmd.wr_leftover)
        begin
            we_type  = 1'b1;
            we_start = 1'b1;
            we_end   = 1'b1;
            wtype    = hit_type_reg;
            wstart   = hit_top_reg;
            wend     = hit_end_reg;
        end
        else if (cmd.wr_hit_end)
        begin
            we_end = 1'b1;
            waddr  = hit_idx_reg;
            wend   = hit_addr_reg;
        end
        else if (cmd.wr_best_end)
        begin
            we_end = 1'b1;
            waddr  = best_idx_reg;
            wend   = best_start_reg;
        end
    end

    // Table storage, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                type_reg[i]  <= '0;
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                if (waddr == IDX_W'(i))
                begin
                    if (we_type)
                        type_reg[i] <= wtype;
                    if (we_start)
                        start_reg[i] <= wstart;
                    if (we_end)
                        end_reg[i] <= wend;
                end
            end
        end
    end

    // Request latch, pointer, hit and best trackers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= request;
        if (cmd.hit_save)
        begin
            hit_idx_reg  <= ptr_reg;
            hit_top_reg  <= rd_top;
            hit_addr_reg <= rd_addr;
            hit_end_reg  <= rd_end;
            hit_type_reg <= rd_type;
        end
        if (cmd.best_en && rd_bigger)
        begin
            best_idx_reg   <= ptr_reg;
            best_start_reg <= rd_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            best_size_reg  <= '0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ptr_clr)
                ptr_reg <= '0;
            else if (cmd.ptr_inc)
                ptr_reg <= ptr_reg + 1'b1;
            if (cmd.capture)
            begin
                best_size_reg  <= '0;
                best_found_reg <= 1'b0;
            end
            else if (cmd.best_en && rd_bigger)
            begin
                best_size_reg  <= rd_size;
                best_found_reg <= 1'b1;
            end
        end
    end

    // Result built from the finishing command
    always_comb
    begin
        result_next        = '0;
        result_next.all_ok = ok_reg & ~cmd.clr_ok;
        case (cmd.res_kind)
            RES_LOAD:
            begin
                result_next.granted = 1'b1;
            end
            RES_ALLOC:
            begin
                result_next.granted       = 1'b1;
                result_next.block_address = hit_addr_reg;
            end
            RES_BIG:
            begin
                result_next.granted       = 1'b1;
                result_next.block_address = best_start_reg;
                result_next.block_size    = best_size_reg;
            end
            default:
            begin
                result_next.granted = 1'b0;
            end
        endcase
    end

    // Sticky ok flag, result register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg     <= 1'b1;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.clr_ok)
                ok_reg <= 1'b0;
            if (cmd.finish)
                result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

    // Checks
    a_done_follows_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.finish))
        else $error("result strobe without a finish command");

    a_ok_falls_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(ok_reg) |-> $past(cmd.clr_ok) && $past(cmd.finish))
        else $error("ok flag cleared outside a failed allocation");

endmodule

// File: hdl/rtba_ctrl.sv
// rtba_ctrl: controller state machine of the region table allocator; sequences
// the table scans and writes. Depends on rtba_pkg.
`timescale 1ns / 1ps

module rtba_ctrl
    import rtba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = RES_FAIL;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    cmd.ptr_clr = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.op)
                    OP_LOAD:
                    begin
                        cmd.wr_load  = status.load_ok;
                        cmd.finish   = 1'b1;
                        cmd.res_kind = status.load_ok ? RES_LOAD : RES_FAIL;
                        state_next   = ST_IDLE;
                    end
                    OP_ALLOC:
                    begin
                        state_next = ST_ALLOC_SCAN;
                    end
                    OP_LARGEST:
                    begin
                        state_next = ST_BIG_SCAN;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ALLOC_SCAN:
            begin
                if (status.alloc_hit)
                begin
                    cmd.hit_save = 1'b1;
                    cmd.ptr_clr  = 1'b1;
                    state_next   = status.need_split ? ST_FREE_SCAN : ST_ALLOC_WRITE;
                end
                else if (status.last)
                begin
                    cmd.clr_ok = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_FREE_SCAN:
            begin
                // leftover goes into the first empty slot, else it is dropped
                if (status.slot_empty)
                begin
                    cmd.wr_leftover = 1'b1;
                    state_next      = ST_ALLOC_WRITE;
                end
                else if (status.last)
                begin
                    state_next = ST_ALLOC_WRITE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_ALLOC_WRITE:
            begin
                cmd.wr_hit_end = 1'b1;
                cmd.finish     = 1'b1;
                cmd.res_kind   = RES_ALLOC;
                state_next     = ST_IDLE;
            end
            ST_BIG_SCAN:
            begin
                cmd.best_en = 1'b1;
                if (status.last)
                    state_next = ST_BIG_WRITE;
                else
                    cmd.ptr_inc = 1'b1;
            end
            ST_BIG_WRITE:
            begin
                cmd.wr_best_end = status.best_found;
                cmd.finish      = 1'b1;
                cmd.res_kind    = status.best_found ? RES_BIG : RES_FAIL;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == ST_IDLE))
        else $error("finish did not return to idle");

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            !(cmd.wr_load || cmd.wr_leftover || cmd.wr_hit_end || cmd.wr_best_end))
        else $error("table write while idle");

    a_clr_ok_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_ok |-> cmd.finish && (cmd.res_kind == RES_FAIL))
        else $error("ok flag cleared without a failed result");

endmodule

// File: hdl/region_table_block_allocator.sv
// region_table_block_allocator: top level joining the controller and datapath.
// Depends on rtba_pkg, rtba_ctrl and rtba_dp.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its result appears on
// result, held until the next result, with done high for exactly one cycle,
// and cannot be held off. The block works on one request at a time. A load or
// an unused op code finishes in the decode state, and done rises as busy falls.
// Take-largest walks the table once, one slot per cycle. A 64k allocation
// walks the table to the first usable region, then, if a leftover must move,
// walks again to the first empty slot. The table has a single read pointer and
// a single write port. The table is empty after reset.
module region_table_block_allocator
    import rtba_pkg::*;
#(
    parameter int NUM_REGIONS = NUM_REGIONS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output res_t result,
    output logic done
);

    cmd_t    cmd;
    status_t status;

    // Sequencer
    rtba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Table and result datapath
    rtba_dp #(
        .NUM_REGIONS (NUM_REGIONS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result),
        .done    (done)
    );

endmodule

// File: dv/region_table_block_allocator_tb.sv
// region_table_block_allocator_tb: self-checking bench for the region table allocator.
// Scores every result against an in-bench table model. Directed and random requests.
// Depends on rtba_pkg and region_table_block_allocator in hdl/.
`timescale 1ns / 1ps

module region_table_block_allocator_tb;
    import rtba_pkg::*;

    localparam int NUM_REGIONS = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Longest request walk plus margin, used to catch stray strobes at the end
    localparam int SETTLE_CYCLES = 4 * NUM_REGIONS + 10;
    localparam int MAX_REPORTS = 50;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    res_t result;
    logic done;

    // Model of the region table
    logic [15:0] slot_type [NUM_REGIONS];
    logic [31:0] slot_start [NUM_REGIONS];
    logic [31:0] slot_end [NUM_REGIONS];
    logic ok_sticky;

    res_t pending_results[$];

    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned requests_sent = 0;
    int unsigned loads_done = 0;
    int unsigned blocks_granted = 0;
    int unsigned blocks_refused = 0;
    int unsigned largest_granted = 0;

    region_table_block_allocator #(
        .NUM_REGIONS(NUM_REGIONS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result(result),
        .done(done)
    );

    always #5 clk = ~clk;

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout at %0t ns with %0d results outstanding", $time,
                 pending_results.size());
        $display("** region_table_block_allocator: FAILED **");
        $finish;
    end

    // Apply one request to the table model and return the result it must produce
    function automatic res_t predict_region_op(req_t r);
        res_t x;
        int i;
        int j;
        int best;
        logic [31:0] top;
        logic [31:0] addr;
        logic [31:0] size;
        logic [31:0] best_size;
        logic found;
        logic placed;
        x = '0;
        case (r.op)
            OP_LOAD:
            begin
                if (r.entry_index < NUM_REGIONS)
                begin
                    slot_type[r.entry_index] = r.entry_type;
                    slot_start[r.entry_index] = r.entry_start;
                    slot_end[r.entry_index] = r.entry_end;
                    x.granted = 1'b1;
                    loads_done++;
                end
            end
            OP_ALLOC:
            begin
                found = 1'b0;
                for (i = 0; i < NUM_REGIONS && !found; i++)
                begin
                    if (slot_end[i] != 32'd0 && slot_type[i] == CHIP_TYPE)
                    begin
                        top = slot_end[i] & ALIGN_MASK;
                        addr = top - BLOCK_SIZE;
                        if (top >= BLOCK_SIZE && addr >= slot_start[i])
                        begin
                            found = 1'b1;
                            // Unaligned top part moves to the first empty slot, if any
                            if (top < slot_end[i])
                            begin
                                placed = 1'b0;
                                for (j = 0; j < NUM_REGIONS; j++)
                                begin
                                    if (!placed && slot_end[j] == 32'd0)
                                    begin
                                        slot_type[j] = slot_type[i];
                                        slot_start[j] = top;
                                        slot_end[j] = slot_end[i];
                                        placed = 1'b1;
                                    end
                                end
                            end
                            slot_end[i] = addr;
                            x.block_address = addr;
                            x.granted = 1'b1;
                        end
                    end
                end
                if (found)
                begin
                    blocks_granted++;
                end
                else
                begin
                    ok_sticky = 1'b0;
                    blocks_refused++;
                end
            end
            OP_LARGEST:
            begin
                best = -1;
                best_size = 32'd0;
                // Strictly larger wins, so the lowest slot keeps a tie
                for (i = 0; i < NUM_REGIONS; i++)
                begin
                    size = slot_end[i] - slot_start[i];
                    if (slot_end[i] != 32'd0 && size > best_size)
                    begin
                        best = i;
                        best_size = size;
                    end
                end
                if (best >= 0)
                begin
                    x.block_address = slot_start[best];
                    x.block_size = best_size;
                    x.granted = 1'b1;
                    slot_end[best] = slot_start[best];
                    largest_granted++;
                end
            end
            default:
            begin
            end
        endcase
        x.all_ok = ok_sticky;
        return x;
    endfunction

    // Random request: any of the four op codes, mostly chip-memory regions of modest size
    function automatic req_t random_request();
        req_t r;
        int unsigned pick;
        logic [31:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.op = OP_LOAD;
        else if (pick < 75)
            r.op = OP_ALLOC;
        else if (pick < 93)
            r.op = OP_LARGEST;
        else
            r.op = OP_UNUSED;
        r.entry_index = 3'($urandom_range(0, NUM_REGIONS - 1));
        r.entry_type = ($urandom_range(0, 99) < 70) ? CHIP_TYPE : 16'($urandom);
        base = $urandom;
        case ($urandom_range(0, 9))
            0:
            begin
                r.entry_start = $urandom;
                r.entry_end = $urandom;
            end
            1:
            begin
                r.entry_start = base;
                r.entry_end = 32'd0;
            end
            2:
            begin
                r.entry_start = 32'd0;
                r.entry_end = $urandom_range(0, 32'h0003_0000);
            end
            default:
            begin
                r.entry_start = base;
                r.entry_end = base + $urandom_range(0, 32'h0008_0000);
            end
        endcase
        return r;
    endfunction

    // Present one request and wait until it is taken
    task automatic send_request(input req_t r);
        @(negedge clk);
        start <= 1'b1;
        request <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_results.push_back(predict_region_op(r));
        requests_sent++;
    endtask

    task automatic load_slot(input int idx, input logic [15:0] typ,
                             input logic [31:0] first, input logic [31:0] last);
        req_t r;
        r.op = OP_LOAD;
        r.entry_index = 3'(idx);
        r.entry_type = typ;
        r.entry_start = first;
        r.entry_end = last;
        send_request(r);
    endtask

    // Non-load operation with random payload in the unused fields
    task automatic issue_op(input logic [1:0] code);
        req_t r;
        r = random_request();
        r.op = code;
        send_request(r);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        issue_op(OP_LARGEST);
        issue_op(OP_UNUSED);
    endtask

    // Unaligned end: leftover moves out, then blocks walk down to the start
    task automatic test_alloc_split();
        load_slot(0, CHIP_TYPE, 32'h0010_0000, 32'h0013_8000);
        repeat (3) issue_op(OP_ALLOC);
    endtask

    // Region whose only block sits at address zero
    task automatic test_alloc_zero_address();
        load_slot(2, CHIP_TYPE, 32'h0000_0000, 32'h0001_0000);
        issue_op(OP_ALLOC);
    endtask

    // Too-low region and wrong type are passed over; slots 0/1 fall below start
    task automatic test_alloc_skips();
        load_slot(3, CHIP_TYPE, 32'h0000_0000, 32'h0000_FFFF);
        load_slot(4, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        load_slot(5, CHIP_TYPE, 32'h8000_0000, 32'hFFFF_FFFF);
        issue_op(OP_ALLOC);
    endtask

    // Every slot in use, so the leftover top part is dropped
    task automatic test_no_free_slot();
        load_slot(6, 16'h1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        load_slot(7, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0001);
        load_slot(3, CHIP_TYPE, 32'h4000_0000, 32'h4005_5555);
        issue_op(OP_ALLOC);
    endtask

    // Full-range region first, then a tie where the lower slot must win
    task automatic test_take_largest();
        issue_op(OP_LARGEST);
        load_slot(1, 16'h0005, 32'h1000_0000, 32'h8FFE_0000);
        issue_op(OP_LARGEST);
    endtask

    // A refused allocation clears the flag and nothing sets it again
    task automatic test_ok_flag_sticky();
        load_slot(3, CHIP_TYPE, 32'h4000_0000, 32'h0000_0000);
        load_slot(5, CHIP_TYPE, 32'h8000_0000, 32'h0000_0000);
        issue_op(OP_ALLOC);
        issue_op(OP_ALLOC);
        issue_op(OP_LARGEST);
    endtask

    task automatic test_random_traffic(input int count, input bit with_gaps);
        int k;
        for (k = 0; k < count; k++)
        begin
            send_request(random_request());
            if (with_gaps && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 10));
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (mismatches < MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, want, got);
        mismatches++;
    endtask

    // Result scoreboard
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual 0x%h",
                             $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.block_address !== want.block_address)
                    report_field("block_address", want.block_address, result.block_address);
                if (result.block_size !== want.block_size)
                    report_field("block_size", want.block_size, result.block_size);
                if (result.granted !== want.granted)
                    report_field("granted", 32'(want.granted), 32'(result.granted));
                if (result.all_ok !== want.all_ok)
                    report_field("all_ok", 32'(want.all_ok), 32'(result.all_ok));
                results_checked++;
            end
        end
    end

    // Main sequence
    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        for (i = 0; i < NUM_REGIONS; i++)
        begin
            slot_type[i] = '0;
            slot_start[i] = '0;
            slot_end[i] = '0;
        end
        ok_sticky = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_alloc_split();
        test_alloc_zero_address();
        test_alloc_skips();
        test_no_free_slot();
        test_take_largest();
        test_ok_flag_sticky();
        test_random_traffic(150, 1'b1);
        drain_results();
        test_random_traffic(150, 1'b1);
        test_random_traffic(80, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Scored %0d results for %0d requests: %0d table loads, %0d largest grants,",
                 results_checked, requests_sent, loads_done, largest_granted);
        $display("%0d 64k blocks handed out and %0d allocations refused.",
                 blocks_granted, blocks_refused);
        if (mismatches == 0)
            $display("** region_table_block_allocator: PASSED **");
        else
            $display("** region_table_block_allocator: FAILED **");
        $finish;
    end

endmodule
